// ===== hw/rtl/spcg_pkg.sv =====
`default_nettype none
package spcg_pkg;

   localparam int CoordW = 32;
   localparam int RadW   = 31;
   localparam int DiffW  = 33;
   localparam int SumW   = 66;
   localparam int LenW   = 33;
   localparam int NumW   = 64;
   localparam int QuoW   = 31;

   // item fields carried alongside the arithmetic
   typedef struct packed {
      logic [2:0][CoordW-1:0] lc;
      logic [2:0][CoordW-1:0] rc;
      logic [RadW-1:0]        lr;
      logic [RadW-1:0]        rr;
      logic [2:0]             neg;
      logic [2:0][DiffW-1:0]  dmag;
      logic                   degen;
      logic [LenW-1:0]        len;
   } spcg_side_type;

endpackage
`default_nettype wire

// ===== hw/rtl/spcg_sqrt.sv =====
`default_nettype none
module spcg_sqrt (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          en,
   input  wire                          in_valid,
   input  spcg_pkg::spcg_side_type      in_side,
   input  wire [spcg_pkg::SumW-1:0]     in_rad,
   output logic                         out_valid,
   output spcg_pkg::spcg_side_type      out_side,
   output logic [spcg_pkg::LenW-1:0]    out_root
);
   import spcg_pkg::*;

   localparam int Steps = SumW / 2;
   localparam int Per   = 3;
   localparam int Stg   = (Steps + Per - 1) / Per;
   localparam int RemW  = LenW + 2;

   logic [Stg-1:0]   v_ff;
   spcg_side_type    side_ff [Stg];
   logic [SumW-1:0]  rad_ff  [Stg];
   logic [RemW-1:0]  rem_ff  [Stg];
   logic [LenW-1:0]  root_ff [Stg];

   for (genvar s = 0; s < Stg; s++) begin : g_stg
      logic            v_pre;
      spcg_side_type   side_pre;
      logic [SumW-1:0] rad_pre, rad_in;
      logic [RemW-1:0] rem_pre, rem_in, t;
      logic [LenW-1:0] root_pre, root_in;

      if (s == 0) begin : g_first
         assign v_pre    = in_valid;
         assign side_pre = in_side;
         assign rad_pre  = in_rad;
         assign rem_pre  = '0;
         assign root_pre = '0;
      end else begin : g_next
         assign v_pre    = v_ff[s-1];
         assign side_pre = side_ff[s-1];
         assign rad_pre  = rad_ff[s-1];
         assign rem_pre  = rem_ff[s-1];
         assign root_pre = root_ff[s-1];
      end

      always_comb begin
         rad_in  = rad_pre;
         rem_in  = rem_pre;
         root_in = root_pre;
         t       = '0;
         for (int j = 0; j < Per; j++) begin
            if (s * Per + j < Steps) begin
               t = {rem_in[RemW-3:0], rad_in[SumW-1:SumW-2]};
               rad_in = {rad_in[SumW-3:0], 2'b00};
               if (t >= {root_in, 2'b01}) begin
                  rem_in  = t - {root_in, 2'b01};
                  root_in = {root_in[LenW-2:0], 1'b1};
               end else begin
                  rem_in  = t;
                  root_in = {root_in[LenW-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_pre;
         end
         if (en) begin
            side_ff[s] <= side_pre;
            rad_ff[s]  <= rad_in;
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
         end
      end
   end

   assign out_valid = v_ff[Stg-1];
   assign out_side  = side_ff[Stg-1];
   assign out_root  = root_ff[Stg-1];
endmodule
`default_nettype wire

// ===== hw/rtl/spcg_div.sv =====
`default_nettype none
module spcg_div (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                en,
   input  wire                                in_valid,
   input  spcg_pkg::spcg_side_type            in_side,
   input  wire [2:0][spcg_pkg::NumW-1:0]      in_num,
   input  wire [spcg_pkg::LenW-1:0]           in_den,
   output logic                               out_valid,
   output spcg_pkg::spcg_side_type            out_side,
   output logic [2:0][spcg_pkg::QuoW-1:0]     out_quo
);
   import spcg_pkg::*;

   localparam int Per = 3;
   localparam int Stg = (QuoW + Per - 1) / Per;

   logic [Stg-1:0]          v_ff;
   spcg_side_type           side_ff [Stg];
   logic [LenW-1:0]         den_ff  [Stg];
   logic [2:0][LenW-1:0]    rem_ff  [Stg];
   logic [2:0][QuoW-1:0]    num_ff  [Stg];
   logic [2:0][QuoW-1:0]    quo_ff  [Stg];

   for (genvar s = 0; s < Stg; s++) begin : g_stg
      logic                 v_pre;
      spcg_side_type        side_pre;
      logic [LenW-1:0]      den_pre;
      logic [2:0][LenW-1:0] rem_pre, rem_in;
      logic [2:0][QuoW-1:0] num_pre, num_in, quo_pre, quo_in;
      logic [LenW:0]        t;

      if (s == 0) begin : g_first
         assign v_pre    = in_valid;
         assign side_pre = in_side;
         assign den_pre  = in_den;
         for (genvar l = 0; l < 3; l++) begin : g_ln
            assign rem_pre[l] = {1'b0, in_num[l][NumW-2:QuoW]};
            assign num_pre[l] = in_num[l][QuoW-1:0];
            assign quo_pre[l] = '0;
         end
      end else begin : g_next
         assign v_pre    = v_ff[s-1];
         assign side_pre = side_ff[s-1];
         assign den_pre  = den_ff[s-1];
         assign rem_pre  = rem_ff[s-1];
         assign num_pre  = num_ff[s-1];
         assign quo_pre  = quo_ff[s-1];
      end

      always_comb begin
         rem_in = rem_pre;
         num_in = num_pre;
         quo_in = quo_pre;
         t      = '0;
         for (int l = 0; l < 3; l++) begin
            for (int j = 0; j < Per; j++) begin
               if (s * Per + j < QuoW) begin
                  t = {rem_in[l], num_in[l][QuoW-1]};
                  num_in[l] = {num_in[l][QuoW-2:0], 1'b0};
                  if (t >= {1'b0, den_pre}) begin
                     rem_in[l] = LenW'(t - {1'b0, den_pre});
                     quo_in[l] = {quo_in[l][QuoW-2:0], 1'b1};
                  end else begin
                     rem_in[l] = t[LenW-1:0];
                     quo_in[l] = {quo_in[l][QuoW-2:0], 1'b0};
                  end
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_pre;
         end
         if (en) begin
            side_ff[s] <= side_pre;
            den_ff[s]  <= den_pre;
            rem_ff[s]  <= rem_in;
            num_ff[s]  <= num_in;
            quo_ff[s]  <= quo_in;
         end
      end
   end

   assign out_valid = v_ff[Stg-1];
   assign out_side  = side_ff[Stg-1];
   assign out_quo   = quo_ff[Stg-1];
endmodule
`default_nettype wire

// ===== hw/rtl/sphere_pair_contact_geometry_top.sv =====
// Sphere pair contact geometry.
// Input channel req_*: two sphere centres and radii (Q16.16), valid/ready.
// Result channel rsp_*: separation, both contact points (Q16.16), the unit
// normal from left to right (Q2.30) and a flag for coincident centres.
// One result item for each input item, in order; items are independent.
// Throughput: one item per cycle while the receiver takes results. Pipeline:
// 28 register stages: input, square, sum, 11 square-root stages (3 root
// bits each), dividend, 11 divider stages (3 quotient bits each, three
// lanes), scale, and the output register.
// The whole pipeline advances together whenever the output register is
// empty or being taken; when the receiver stalls every stage holds, so no
// item is lost or repeated, and req_ready falls in the same cycle.
// Synchronous reset clears all valid bits; payload registers are not reset.
`default_nettype none
module sphere_pair_contact_geometry_top (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire signed [31:0]  req_left_x,
   input  wire signed [31:0]  req_left_y,
   input  wire signed [31:0]  req_left_z,
   input  wire signed [31:0]  req_right_x,
   input  wire signed [31:0]  req_right_y,
   input  wire signed [31:0]  req_right_z,
   input  wire [30:0]         req_left_radius,
   input  wire [30:0]         req_right_radius,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic signed [31:0] rsp_separation,
   output logic signed [31:0] rsp_left_contact_x,
   output logic signed [31:0] rsp_left_contact_y,
   output logic signed [31:0] rsp_left_contact_z,
   output logic signed [31:0] rsp_right_contact_x,
   output logic signed [31:0] rsp_right_contact_y,
   output logic signed [31:0] rsp_right_contact_z,
   output logic signed [31:0] rsp_normal_x,
   output logic signed [31:0] rsp_normal_y,
   output logic signed [31:0] rsp_normal_z,
   output logic               rsp_degenerate
);
   import spcg_pkg::*;

   localparam int ProdW = RadW + QuoW;

   function automatic logic [31:0] sat34(input logic signed [33:0] v);
      if (v > 34'sd2147483647) begin
         sat34 = 32'h7fffffff;
      end else if (v < -34'sd2147483648) begin
         sat34 = 32'h80000000;
      end else begin
         sat34 = v[31:0];
      end
   endfunction

   // one enable for every stage: advance unless the output is held
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // input stage: differences and magnitudes
   logic          s0_v_ff;
   spcg_side_type s0_side_ff, s0_side_in;
   logic [2:0][31:0] lc_w, rc_w;

   assign lc_w = {req_left_z, req_left_y, req_left_x};
   assign rc_w = {req_right_z, req_right_y, req_right_x};

   always_comb begin
      logic signed [DiffW-1:0] d;
      s0_side_in       = '0;
      s0_side_in.lc    = lc_w;
      s0_side_in.rc    = rc_w;
      s0_side_in.lr    = req_left_radius;
      s0_side_in.rr    = req_right_radius;
      for (int i = 0; i < 3; i++) begin
         d = DiffW'($signed(rc_w[i])) - DiffW'($signed(lc_w[i]));
         s0_side_in.neg[i]  = d[DiffW-1];
         s0_side_in.dmag[i] = d[DiffW-1] ? DiffW'(-d) : DiffW'(d);
      end
   end

   // squares
   logic                 s1_v_ff;
   spcg_side_type        s1_side_ff;
   logic [2:0][SumW-1:0] s1_sq_ff;

   // sum of squares
   logic            s2_v_ff;
   spcg_side_type   s2_side_ff;
   logic [SumW-1:0] s2_sum_ff;

   always_ff @(posedge clock) begin
      spcg_side_type s2_side_w;
      if (reset) begin
         s0_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else if (en) begin
         s0_v_ff <= req_valid;
         s1_v_ff <= s0_v_ff;
         s2_v_ff <= s1_v_ff;
      end
      if (en) begin
         s0_side_ff <= s0_side_in;
         s1_side_ff <= s0_side_ff;
         for (int i = 0; i < 3; i++) begin
            s1_sq_ff[i] <= SumW'(s0_side_ff.dmag[i]) * SumW'(s0_side_ff.dmag[i]);
         end
         s2_side_w       = s1_side_ff;
         s2_side_w.degen = (s1_sq_ff[0] | s1_sq_ff[1] | s1_sq_ff[2]) == '0;
         s2_side_ff      <= s2_side_w;
         s2_sum_ff       <= s1_sq_ff[0] + s1_sq_ff[1] + s1_sq_ff[2];
      end
   end

   logic            sq_v;
   spcg_side_type   sq_side;
   logic [LenW-1:0] sq_root;

   spcg_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s2_v_ff),
      .in_side   (s2_side_ff),
      .in_rad    (s2_sum_ff),
      .out_valid (sq_v),
      .out_side  (sq_side),
      .out_root  (sq_root)
   );

   // dividend: |d| * 2^30 + len/2, for round-to-nearest quotient
   logic                 s3_v_ff;
   spcg_side_type        s3_side_ff;
   logic [2:0][NumW-1:0] s3_num_ff;

   always_ff @(posedge clock) begin
      spcg_side_type s3_side_w;
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s3_v_ff <= sq_v;
      end
      if (en) begin
         s3_side_w     = sq_side;
         s3_side_w.len = sq_root;
         s3_side_ff    <= s3_side_w;
         for (int i = 0; i < 3; i++) begin
            s3_num_ff[i] <= {NumW'(sq_side.dmag[i]) << 30} + NumW'(sq_root >> 1);
         end
      end
   end

   logic                 dv_v;
   spcg_side_type        dv_side;
   logic [2:0][QuoW-1:0] dv_quo;

   spcg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_v_ff),
      .in_side   (s3_side_ff),
      .in_num    (s3_num_ff),
      .in_den    (s3_side_ff.len),
      .out_valid (dv_v),
      .out_side  (dv_side),
      .out_quo   (dv_quo)
   );

   // signed normal and radius products
   logic                  s4_v_ff;
   spcg_side_type         s4_side_ff;
   logic [2:0][31:0]      s4_n_ff;
   logic [2:0][ProdW-1:0] s4_lp_ff, s4_rp_ff;

   always_ff @(posedge clock) begin
      logic [QuoW-1:0] q;
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (en) begin
         s4_v_ff <= dv_v;
      end
      if (en) begin
         s4_side_ff <= dv_side;
         for (int i = 0; i < 3; i++) begin
            q = (dv_side.degen || dv_side.len == '0) ? '0 : dv_quo[i];
            s4_n_ff[i]  <= dv_side.neg[i] ? -{1'b0, q} : {1'b0, q};
            s4_lp_ff[i] <= ProdW'(dv_side.lr) * ProdW'(q);
            s4_rp_ff[i] <= ProdW'(dv_side.rr) * ProdW'(q);
         end
      end
   end

   // rounding, contact sums, saturation into the output register
   logic             out_v_ff;
   logic [31:0]      sep_ff;
   logic [2:0][31:0] lcon_ff, rcon_ff, nrm_ff;
   logic             degen_ff;

   always_ff @(posedge clock) begin
      logic [ProdW-1:0]    lr_r, rr_r;
      logic signed [33:0]  lo, ro;
      logic signed [34:0]  sep;
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= s4_v_ff;
      end
      if (en) begin
         sep = 35'(s4_side_ff.len) - 35'(s4_side_ff.lr) - 35'(s4_side_ff.rr);
         if (sep > 35'sd2147483647) begin
            sep_ff <= 32'h7fffffff;
         end else if (sep < -35'sd2147483648) begin
            sep_ff <= 32'h80000000;
         end else begin
            sep_ff <= sep[31:0];
         end
         for (int i = 0; i < 3; i++) begin
            lr_r = (s4_lp_ff[i] + (ProdW'(1) << 29)) >> 30;
            rr_r = (s4_rp_ff[i] + (ProdW'(1) << 29)) >> 30;
            lo = s4_side_ff.neg[i] ? -$signed({2'b00, lr_r[31:0]})
                                   : $signed({2'b00, lr_r[31:0]});
            ro = s4_side_ff.neg[i] ? -$signed({2'b00, rr_r[31:0]})
                                   : $signed({2'b00, rr_r[31:0]});
            lcon_ff[i] <= sat34(34'($signed(s4_side_ff.lc[i])) + lo);
            rcon_ff[i] <= sat34(34'($signed(s4_side_ff.rc[i])) - ro);
         end
         nrm_ff   <= s4_n_ff;
         degen_ff <= s4_side_ff.degen;
      end
   end

   assign rsp_valid           = out_v_ff;
   assign rsp_separation      = sep_ff;
   assign rsp_left_contact_x  = lcon_ff[0];
   assign rsp_left_contact_y  = lcon_ff[1];
   assign rsp_left_contact_z  = lcon_ff[2];
   assign rsp_right_contact_x = rcon_ff[0];
   assign rsp_right_contact_y = rcon_ff[1];
   assign rsp_right_contact_z = rcon_ff[2];
   assign rsp_normal_x        = nrm_ff[0];
   assign rsp_normal_y        = nrm_ff[1];
   assign rsp_normal_z        = nrm_ff[2];
   assign rsp_degenerate      = degen_ff;
endmodule
`default_nettype wire

// ===== tb/sv/tb_sphere_pair_contact_geometry_top.sv =====
`default_nettype none
module tb_sphere_pair_contact_geometry_top;
   timeunit 1ns;
   timeprecision 1ps;

   // one sphere pair as it goes into the block
   typedef struct {
      logic signed [31:0] lc [3];
      logic signed [31:0] rc [3];
      logic [30:0]        lr;
      logic [30:0]        rr;
   } pair_type;

   // one contact result as it should come out
   typedef struct {
      logic signed [31:0] sep;
      logic signed [31:0] lcon [3];
      logic signed [31:0] rcon [3];
      logic signed [31:0] nrm [3];
      logic               degen;
   } contact_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   wire                req_ready;
   logic signed [31:0] req_left_x = '0, req_left_y = '0, req_left_z = '0;
   logic signed [31:0] req_right_x = '0, req_right_y = '0, req_right_z = '0;
   logic [30:0]        req_left_radius = '0, req_right_radius = '0;
   wire                rsp_valid;
   logic               rsp_ready = 1'b0;
   wire signed [31:0]  rsp_separation;
   wire signed [31:0]  rsp_left_contact_x, rsp_left_contact_y, rsp_left_contact_z;
   wire signed [31:0]  rsp_right_contact_x, rsp_right_contact_y, rsp_right_contact_z;
   wire signed [31:0]  rsp_normal_x, rsp_normal_y, rsp_normal_z;
   wire                rsp_degenerate;

   sphere_pair_contact_geometry_top i_dut (
      .clock, .reset,
      .req_valid, .req_ready,
      .req_left_x, .req_left_y, .req_left_z,
      .req_right_x, .req_right_y, .req_right_z,
      .req_left_radius, .req_right_radius,
      .rsp_valid, .rsp_ready,
      .rsp_separation,
      .rsp_left_contact_x, .rsp_left_contact_y, .rsp_left_contact_z,
      .rsp_right_contact_x, .rsp_right_contact_y, .rsp_right_contact_z,
      .rsp_normal_x, .rsp_normal_y, .rsp_normal_z,
      .rsp_degenerate
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   pair_type    pending_pairs [$];
   contact_type expected_contacts [$];
   int          error_count = 0;
   bit          hold_sender = 0;   // sender pause, raised once the pipe has drained
   int          stall_cycles = 0;  // long receiver hold-off, counted down here

   // ---------------------------------------------------------------------
   // contact geometry predictor
   // ---------------------------------------------------------------------
   function automatic logic signed [31:0] sat32(logic signed [67:0] v);
      if (v > 68'sd2147483647) return 32'sh7fffffff;
      if (v < -68'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // radius * n / 2^30, rounded, ties away from zero
   function automatic logic signed [67:0] contact_offset(logic [30:0] r,
                                                         logic signed [31:0] n);
      logic [63:0] m;
      logic [31:0] an;
      an = n < 0 ? -n : n;
      m  = ({33'd0, r} * {32'd0, an} + 64'd536870912) >> 30;
      return n < 0 ? -$signed({4'd0, m}) : $signed({4'd0, m});
   endfunction

   function automatic contact_type predict_contact(pair_type p);
      contact_type c;
      logic signed [32:0] d [3];
      logic [32:0] ad [3];
      logic [65:0] sum;
      logic [33:0] root, cand;
      logic [67:0] sq;
      logic [63:0] q;
      sum = '0;
      for (int i = 0; i < 3; i++) begin
         d[i]  = $signed({p.rc[i][31], p.rc[i]}) - $signed({p.lc[i][31], p.lc[i]});
         ad[i] = d[i] < 0 ? -d[i] : d[i];
         sum   = sum + {33'd0, ad[i]} * {33'd0, ad[i]};
      end
      c.degen = (sum == 0);
      root = '0;
      for (int b = 33; b >= 0; b--) begin
         cand = root | (34'd1 << b);
         sq   = {34'd0, cand} * {34'd0, cand};
         if (sq <= {2'd0, sum}) root = cand;
      end
      for (int i = 0; i < 3; i++) begin
         if (root == 0) c.nrm[i] = '0;
         else begin
            q = (({31'd0, ad[i]} << 30) + {31'd0, root[33:1]}) / {30'd0, root};
            c.nrm[i] = d[i] < 0 ? -q[31:0] : q[31:0];
         end
      end
      c.sep = sat32($signed({34'd0, root}) - $signed({37'd0, p.lr})
                    - $signed({37'd0, p.rr}));
      for (int i = 0; i < 3; i++) begin
         c.lcon[i] = sat32($signed({{36{p.lc[i][31]}}, p.lc[i]})
                           + contact_offset(p.lr, c.nrm[i]));
         c.rcon[i] = sat32($signed({{36{p.rc[i][31]}}, p.rc[i]})
                           - contact_offset(p.rr, c.nrm[i]));
      end
      return c;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      error_count++;
   endtask

   // ---------------------------------------------------------------------
   // driver: bursts of items with random gaps
   // ---------------------------------------------------------------------
   int gap_left = 0, burst_left = 0;
   always @(posedge clock) begin
      pair_type p;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_contacts.push_back(predict_contact(pending_pairs.pop_front()));
         end
         // valid held until accepted; only choose again once free
         if (!(req_valid && !req_ready)) begin
            if (gap_left > 0 || hold_sender || pending_pairs.size() == 0 ||
                (req_valid && req_ready && pending_pairs.size() == 0)) begin
               req_valid <= 1'b0;
               if (gap_left > 0) gap_left--;
            end else begin
               p = pending_pairs[0];
               req_valid        <= 1'b1;
               req_left_x       <= p.lc[0];
               req_left_y       <= p.lc[1];
               req_left_z       <= p.lc[2];
               req_right_x      <= p.rc[0];
               req_right_y      <= p.rc[1];
               req_right_z      <= p.rc[2];
               req_left_radius  <= p.lr;
               req_right_radius <= p.rr;
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(40, 1);
                  gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: result stalls on their own pattern, plus a long hold-off
   // ---------------------------------------------------------------------
   int rsp_phase = 0;
   always @(posedge clock) begin
      contact_type w;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_contacts.size() == 0) begin
               report_mismatch("unexpected item", rsp_separation, 32'd0);
            end else begin
               w = expected_contacts.pop_front();
               if (rsp_separation !== w.sep)
                  report_mismatch("separation", rsp_separation, w.sep);
               if (rsp_left_contact_x !== w.lcon[0])
                  report_mismatch("left_contact_x", rsp_left_contact_x, w.lcon[0]);
               if (rsp_left_contact_y !== w.lcon[1])
                  report_mismatch("left_contact_y", rsp_left_contact_y, w.lcon[1]);
               if (rsp_left_contact_z !== w.lcon[2])
                  report_mismatch("left_contact_z", rsp_left_contact_z, w.lcon[2]);
               if (rsp_right_contact_x !== w.rcon[0])
                  report_mismatch("right_contact_x", rsp_right_contact_x, w.rcon[0]);
               if (rsp_right_contact_y !== w.rcon[1])
                  report_mismatch("right_contact_y", rsp_right_contact_y, w.rcon[1]);
               if (rsp_right_contact_z !== w.rcon[2])
                  report_mismatch("right_contact_z", rsp_right_contact_z, w.rcon[2]);
               if (rsp_normal_x !== w.nrm[0])
                  report_mismatch("normal_x", rsp_normal_x, w.nrm[0]);
               if (rsp_normal_y !== w.nrm[1])
                  report_mismatch("normal_y", rsp_normal_y, w.nrm[1]);
               if (rsp_normal_z !== w.nrm[2])
                  report_mismatch("normal_z", rsp_normal_z, w.nrm[2]);
               if (rsp_degenerate !== w.degen)
                  report_mismatch("degenerate", {31'd0, rsp_degenerate}, {31'd0, w.degen});
            end
         end
         rsp_phase++;
         if (stall_cycles > 0) begin
            stall_cycles--;
            rsp_ready <= 1'b0;
         end else if ((rsp_phase / 300) % 3 == 2) begin
            rsp_ready <= 1'b1;           // stretch with no stalls
         end else begin
            rsp_ready <= (rsp_phase % 7 != 3) && ($urandom_range(4, 0) != 0);
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   function automatic logic [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom();
         1: return $urandom_range(2000, 0) - 1000;
         2: return $urandom_range(1, 0) ? 32'h7fffffff - $urandom_range(3, 0)
                                        : 32'h80000000 + $urandom_range(3, 0);
         default: return ($urandom() & 32'h000fffff) - 32'h00080000;
      endcase
   endfunction

   task automatic add_pair(logic [31:0] lx, ly, lz, rx, ry, rz,
                           logic [30:0] lr, rr);
      pair_type p;
      p.lc[0] = lx; p.lc[1] = ly; p.lc[2] = lz;
      p.rc[0] = rx; p.rc[1] = ry; p.rc[2] = rz;
      p.lr = lr; p.rr = rr;
      pending_pairs.push_back(p);
   endtask

   task automatic add_random_pair();
      logic [31:0] l [3], r [3];
      int m;
      m = $urandom_range(3, 0);
      for (int i = 0; i < 3; i++) begin
         l[i] = rand_coord(m);
         r[i] = ($urandom_range(9, 0) == 0) ? l[i] : rand_coord(m);
      end
      if ($urandom_range(29, 0) == 0) r = l;   // coincident centres
      add_pair(l[0], l[1], l[2], r[0], r[1], r[2],
               $urandom_range(1, 0) ? 31'($urandom()) : 31'($urandom_range(1 << 20, 0)),
               $urandom_range(1, 0) ? 31'($urandom()) : 31'($urandom_range(1 << 20, 0)));
   endtask

   task automatic wait_drained();
      while (pending_pairs.size() != 0 || req_valid || expected_contacts.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      add_pair(0, 0, 0, 0, 0, 0, 31'd0, 31'd0);                  // coincident, zero radii
      add_pair(5, 6, 7, 5, 6, 7, 31'h7fffffff, 31'h7fffffff);    // coincident, max radii
      add_pair(32'h80000000, 32'h80000000, 32'h80000000,
               32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
               31'h7fffffff, 31'h7fffffff);                      // longest span
      add_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
               32'h80000000, 32'h80000000, 32'h80000000,
               31'h7fffffff, 31'h7fffffff);
      add_pair(0, 0, 0, 32'h00010000, 0, 0, 31'h00008000, 31'h00008000); // touching
      add_pair(0, 0, 0, 0, 32'hffff0000, 0, 31'h00020000, 31'd1);  // overlap
      add_pair(0, 0, 0, 0, 0, 1, 31'd0, 31'h7fffffff);           // smallest span
      add_pair(32'h7fffffff, 0, 0, 32'h7ffffffe, 0, 0, 31'h7fffffff, 31'd0);
      add_pair(32'h80000000, 0, 0, 32'h80000001, 0, 0, 31'h7fffffff, 31'd0);
      add_pair(1, 1, 0, 0, 0, 0, 31'd3, 31'd3);
      add_pair(0, 0, 0, 3, 4, 12, 31'h55555555, 31'h2aaaaaaa);
      add_pair(32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0, 31'd1, 31'd1);
      wait_drained();

      // long receiver hold-off while the sender keeps offering
      stall_cycles = 200;
      for (int k = 0; k < 80; k++) add_random_pair();
      wait_drained();

      for (int k = 0; k < 1600; k++) begin
         add_random_pair();
         if (k == 800) begin
            // sender pause until every result is in
            wait_drained();
            hold_sender = 1;
            repeat (5) @(posedge clock);
            hold_sender = 0;
         end
      end
      wait_drained();
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire
